/* design/spbc_pkg.sv */
// ----------------------------------------------------------------------------
// spbc_pkg
// Shared types and constants for the soft power button controller.
// ----------------------------------------------------------------------------
package spbc_pkg;

  // counter and configuration widths
  localparam int COUNT_WIDTH = 16;
  localparam int REG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;

  // stream payload widths
  localparam int IN_DATA_WIDTH  = 8;
  localparam int OUT_DATA_WIDTH = 8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFF_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_ON    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_OFF   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SETTLE      = 2'd3;

  // configuration reset values
  localparam logic [REG_WIDTH-1:0] OFF_TIMEOUT_RESET = 16'd850;
  localparam logic [REG_WIDTH-1:0] PRESS_ON_RESET    = 16'd85;
  localparam logic [REG_WIDTH-1:0] PRESS_OFF_RESET   = 16'd340;
  localparam logic [REG_WIDTH-1:0] SETTLE_RESET      = 16'd255;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] off_timeout_ticks;
    logic [REG_WIDTH-1:0] press_on_ticks;
    logic [REG_WIDTH-1:0] press_off_ticks;
    logic [REG_WIDTH-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                  mode;
    logic [COUNT_WIDTH-1:0] press_count;
    logic [COUNT_WIDTH-1:0] wait_count;
    logic                   power;
    logic                   button_drive;
    logic                   last_button;
    logic                   last_request;
  } ctl_state_t;

  localparam ctl_state_t STATE_RESET = '{
    mode:         MODE_OFF,
    press_count:  '0,
    wait_count:   '0,
    power:        1'b0,
    button_drive: 1'b0,
    last_button:  1'b0,
    last_request: 1'b0
  };

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  // counter strictly above a limit
  function automatic logic above(input logic [COUNT_WIDTH-1:0] cnt,
                                 input logic [REG_WIDTH-1:0] lim);
    above = CMP_WIDTH'(cnt) > CMP_WIDTH'(lim);
  endfunction

endpackage

/* design/spbc_step.sv */
// ----------------------------------------------------------------------------
// spbc_step
// Next-state logic for one poll tick: counters, mode decisions and outputs.
// ----------------------------------------------------------------------------
module spbc_step (
  input  spbc_pkg::ctl_state_t cur,
  input  spbc_pkg::cfg_t       cfg,
  input  logic                 button_pressed,
  input  logic                 cpu_request,
  output spbc_pkg::ctl_state_t nxt
);
  import spbc_pkg::*;

  logic [COUNT_WIDTH-1:0] press_inc;
  logic [COUNT_WIDTH-1:0] wait_inc;
  logic                   woken;

  assign press_inc = button_pressed ? sat_inc(cur.press_count) : '0;
  assign wait_inc  = sat_inc(cur.wait_count);
  assign woken     = (button_pressed != cur.last_button) ||
                     (cpu_request != cur.last_request);

  // tick update, off-mode checks applied in priority order
  always_comb begin
    nxt = cur;
    if (cur.mode == MODE_SLEEP) begin
      if (woken) begin
        nxt = STATE_RESET;
      end
    end else begin
      nxt.press_count  = press_inc;
      nxt.wait_count   = wait_inc;
      nxt.last_button  = button_pressed;
      nxt.last_request = cpu_request;
      case (cur.mode)
        MODE_OFF: begin
          if (above(wait_inc, cfg.off_timeout_ticks)) begin
            nxt.power = 1'b0;
            nxt.mode  = MODE_WAIT;
          end
          if (above(press_inc, cfg.press_on_ticks)) begin
            nxt.power      = 1'b1;
            nxt.wait_count = '0;
          end
          if (cpu_request) begin
            nxt.power = 1'b1;
            nxt.mode  = MODE_ON;
          end
        end
        MODE_ON: begin
          if (!cpu_request || above(press_inc, cfg.press_off_ticks)) begin
            nxt.power        = 1'b0;
            nxt.button_drive = 1'b0;
            nxt.wait_count   = '0;
            nxt.mode         = MODE_WAIT;
          end else begin
            nxt.button_drive = (press_inc != '0);
          end
        end
        MODE_WAIT: begin
          if (above(wait_inc, cfg.settle_ticks)) begin
            nxt.mode = MODE_SLEEP;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

/* design/soft_power_button_controller_core.sv */
// ----------------------------------------------------------------------------
// soft_power_button_controller_core
// Poll-tick power button controller with stream input and result channels.
// ----------------------------------------------------------------------------
// result: the outputs of a tick are loaded into the output register when the tick is taken
// throughput: one tick per cycle while m_tready takes results; the output register refills as it drains
// reset: synchronous, clears mode, counters, controller outputs and result valid,
//   and loads the default tick limits into the configuration registers
module soft_power_button_controller_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata: [0] button_pressed, [1] cpu_request, rest zero
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [spbc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  // m_tdata: [0] power_enable, [1] cpu_button_low, [3:2] mode, rest zero
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [spbc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
  input  logic                                  cfg_we,
  input  logic [spbc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [spbc_pkg::REG_WIDTH-1:0]        cfg_data
);
  import spbc_pkg::*;

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  logic       accept;
  logic       power_out;
  logic       drive_out;
  mode_t      mode_out;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_timeout_ticks <= OFF_TIMEOUT_RESET;
      cfg.press_on_ticks    <= PRESS_ON_RESET;
      cfg.press_off_ticks   <= PRESS_OFF_RESET;
      cfg.settle_ticks      <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFF_TIMEOUT: cfg.off_timeout_ticks <= cfg_data;
        CFG_PRESS_ON:    cfg.press_on_ticks    <= cfg_data;
        CFG_PRESS_OFF:   cfg.press_off_ticks   <= cfg_data;
        CFG_SETTLE:      cfg.settle_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spbc_step u_step (
    .cur            (state),
    .cfg            (cfg),
    .button_pressed (s_tdata[0]),
    .cpu_request    (s_tdata[1]),
    .nxt            (state_next)
  );

  // controller state advances on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      power_out <= state_next.power;
      drive_out <= state_next.button_drive;
      mode_out  <= state_next.mode;
    end
  end

  assign m_tdata = {{(OUT_DATA_WIDTH-4){1'b0}}, mode_out, drive_out, power_out};

endmodule

/* tb/spbc_tick_checker.sv */
// ----------------------------------------------------------------------------
// spbc_tick_checker
// Watches the tick and result streams and the configuration port, predicts
// the outputs of each accepted tick request and compares them with the results
// leaving the block.
// ----------------------------------------------------------------------------
module spbc_tick_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  // s_tdata: [0] button_pressed, [1] cpu_request, rest zero
  input  logic [spbc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: [0] power_enable, [1] cpu_button_low, [3:2] mode, rest zero
  input  logic [spbc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
  input  logic                                  cfg_we,
  input  logic [spbc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [spbc_pkg::REG_WIDTH-1:0]        cfg_data,
  output int                                    errors,
  output int                                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import spbc_pkg::*;

  typedef struct packed {
    logic  power;
    logic  button_low;
    mode_t mode;
  } tick_out_t;

  localparam logic [COUNT_WIDTH-1:0] RUN_TOP = {COUNT_WIDTH{1'b1}};

  // mirrored tick limits
  logic [REG_WIDTH-1:0]   lim_off_timeout;
  logic [REG_WIDTH-1:0]   lim_press_on;
  logic [REG_WIDTH-1:0]   lim_press_off;
  logic [REG_WIDTH-1:0]   lim_settle;

  // mirrored controller state
  mode_t                  cur_mode;
  logic [COUNT_WIDTH-1:0] press_run;
  logic [COUNT_WIDTH-1:0] wait_run;
  logic                   power_on;
  logic                   drive_low;
  logic                   seen_button;
  logic                   seen_request;

  tick_out_t              expected_outputs_q[$];
  int                     fail_total = 0;

  // counters hold at the top instead of wrapping
  function automatic logic [COUNT_WIDTH-1:0] hold_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == RUN_TOP) ? RUN_TOP : v + 1'b1;
  endfunction

  task automatic clear_controller();
    cur_mode     = MODE_OFF;
    press_run    = '0;
    wait_run     = '0;
    power_on     = 1'b0;
    drive_low    = 1'b0;
    seen_button  = 1'b0;
    seen_request = 1'b0;
  endtask

  // one poll tick of the controller
  task automatic step_power_controller(input logic btn, input logic req,
                                       output tick_out_t res);
    if (cur_mode == MODE_SLEEP) begin
      // any level change wakes with reset values
      if (btn != seen_button || req != seen_request) clear_controller();
    end else begin
      press_run    = btn ? hold_inc(press_run) : '0;
      wait_run     = hold_inc(wait_run);
      seen_button  = btn;
      seen_request = req;
      case (cur_mode)
        MODE_OFF: begin
          // timeout, then long press, then cpu request
          if (wait_run > lim_off_timeout) begin
            power_on = 1'b0;
            cur_mode = MODE_WAIT;
          end
          if (press_run > lim_press_on) begin
            power_on = 1'b1;
            wait_run = '0;
          end
          if (req) begin
            power_on = 1'b1;
            cur_mode = MODE_ON;
          end
        end
        MODE_ON: begin
          if (!req || press_run > lim_press_off) begin
            power_on  = 1'b0;
            drive_low = 1'b0;
            wait_run  = '0;
            cur_mode  = MODE_WAIT;
          end else begin
            drive_low = (press_run != '0);
          end
        end
        default: begin
          if (wait_run > lim_settle) cur_mode = MODE_SLEEP;
        end
      endcase
    end
    res = '{power: power_on, button_low: drive_low, mode: cur_mode};
  endtask

  // watch the ports, predict and compare
  always @(posedge clk) begin : watch
    tick_out_t res;
    tick_out_t exp;
    if (rst) begin
      lim_off_timeout = OFF_TIMEOUT_RESET;
      lim_press_on    = PRESS_ON_RESET;
      lim_press_off   = PRESS_OFF_RESET;
      lim_settle      = SETTLE_RESET;
      clear_controller();
      expected_outputs_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFF_TIMEOUT: lim_off_timeout = cfg_data;
          CFG_PRESS_ON:    lim_press_on    = cfg_data;
          CFG_PRESS_OFF:   lim_press_off   = cfg_data;
          CFG_SETTLE:      lim_settle      = cfg_data;
          default: ;
        endcase
      end
      // results are compared before this edge's request is predicted
      if (m_tvalid && m_tready) begin
        if (expected_outputs_q.size() == 0) begin
          $error("result with no request pending: m_tdata %h", m_tdata);
          fail_total++;
        end else begin
          exp = expected_outputs_q.pop_front();
          if (m_tdata[0] !== exp.power) begin
            $error("power_enable mismatch: expected %0d, actual %0d", exp.power, m_tdata[0]);
            fail_total++;
          end
          if (m_tdata[1] !== exp.button_low) begin
            $error("cpu_button_low mismatch: expected %0d, actual %0d",
                   exp.button_low, m_tdata[1]);
            fail_total++;
          end
          if (m_tdata[3:2] !== exp.mode) begin
            $error("mode mismatch: expected %0d, actual %0d", exp.mode, m_tdata[3:2]);
            fail_total++;
          end
          if (m_tdata[OUT_DATA_WIDTH-1:4] !== '0) begin
            $error("padding mismatch: expected 0, actual %0h", m_tdata[OUT_DATA_WIDTH-1:4]);
            fail_total++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        step_power_controller(s_tdata[0], s_tdata[1], res);
        expected_outputs_q.push_back(res);
      end
    end
    outstanding <= expected_outputs_q.size();
    errors      <= fail_total;
  end

endmodule

/* tb/tb_soft_power_button_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_soft_power_button_controller_core
// Drives poll ticks into the power button controller in random bursts while
// the result side stalls on its own pattern. A directed run covers every mode
// change and wake-up, a held press under top limits shows compares that never
// pass, and random phases under changing tick limits cover the rest. Checking
// is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_soft_power_button_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spbc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [REG_WIDTH-1:0] LIM_TOP = {REG_WIDTH{1'b1}};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_DATA_WIDTH-1:0]   s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0]  m_tdata;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_OFF_TIMEOUT;
  logic [REG_WIDTH-1:0]       cfg_data = '0;

  int                         errors;
  int                         outstanding;
  int                         burst_left = 0;
  logic [7:0]                 ready_cycle = '0;
  logic [1:0]                 ready_style = 2'd0;

  initial begin
    forever #6 clk = ~clk;
  end

  soft_power_button_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spbc_tick_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // result side stalls, style redrawn whenever ready_cycle[6:0] is zero
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1'b1;
    if (ready_cycle[6:0] == 7'd0) ready_style <= 2'($urandom_range(0, 3));
    case (ready_style)
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_tready <= (ready_cycle[1:0] == 2'd3);
      default: m_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_soft_power_button_controller_core NOT OK");
    $finish;
  end

  // one tick request, with a random gap when a burst runs out
  task automatic send_tick(input logic btn, input logic req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_WIDTH'({req, btn});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all four tick limits while the block is idle
  task automatic load_limits(input logic [REG_WIDTH-1:0] off_timeout,
                             input logic [REG_WIDTH-1:0] press_on,
                             input logic [REG_WIDTH-1:0] press_off,
                             input logic [REG_WIDTH-1:0] settle);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OFF_TIMEOUT;
    cfg_data  <= off_timeout;
    @(posedge clk);
    cfg_index <= CFG_PRESS_ON;
    cfg_data  <= press_on;
    @(posedge clk);
    cfg_index <= CFG_PRESS_OFF;
    cfg_data  <= press_off;
    @(posedge clk);
    cfg_index <= CFG_SETTLE;
    cfg_data  <= settle;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REG_WIDTH-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return LIM_TOP;
      1, 2:    return REG_WIDTH'($urandom_range(0, 40));
      default: return REG_WIDTH'($urandom_range(0, 10));
    endcase
  endfunction

  // runs of steady levels with some single-tick noise
  task automatic random_traffic(input int count);
    int   left;
    int   run;
    logic btn;
    logic req;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0, 1:    {btn, req} = 2'b01;
        2, 3:    {btn, req} = 2'b11;
        4:       {btn, req} = 2'b10;
        5:       {btn, req} = 2'b00;
        default: {btn, req} = 2'($urandom_range(0, 3));
      endcase
      while (run > 0 && left > 0) begin
        if ($urandom_range(0, 11) == 0) send_tick(1'($urandom), 1'($urandom));
        else send_tick(btn, req);
        run--;
        left--;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default limits: request on, copy button, request drop
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // short limits: long press, timeout, sleep, wake, forced power-down
    load_limits(16'd4, 16'd1, 16'd2, 16'd1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (6) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);

    // top limits: a held press never passes any compare
    load_limits(LIM_TOP, LIM_TOP, LIM_TOP, LIM_TOP);
    repeat (40) send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0);

    // random phases, first one with every limit at zero
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 0) load_limits('0, '0, '0, '0);
      else load_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
      random_traffic(90);
    end

    drain();
    if (errors == 0) begin
      $display("tb_soft_power_button_controller_core OK");
    end else begin
      $display("tb_soft_power_button_controller_core NOT OK");
    end
    $finish;
  end

endmodule
